FILE: hdl/mbf_pkg.sv
// Package with shared types and constants of the MAC Bloom filter.
package mbf_pkg;
   localparam int unsigned MAX_BITS   = 65536;
   localparam int unsigned MAX_HASHES = 20;
   localparam int unsigned IDX_W      = $clog2(MAX_BITS);
   localparam int unsigned SIZE_W     = 17;
   localparam int unsigned NH_W       = 5;
   localparam int unsigned MAC_W      = 48;
   localparam logic [31:0] FNV_START  = 32'd2166136261;
   localparam logic [31:0] FNV_MULT   = 32'd16777619;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      REG_BIT_SIZE = 1'b0,
      REG_NUM_HASH = 1'b1
   } reg_type;

   typedef enum logic [3:0] {
      ST_WIPE, ST_IDLE, ST_HASH, ST_MUL, ST_MOD, ST_ACC, ST_WAIT, ST_CHECK, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } unit_ctl_type;
endpackage

FILE: hdl/mbf_ram.sv
// Generic single-port RAM with registered read.
module mbf_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

FILE: hdl/mbf_mul.sv
// Bit-serial multiply of the hash state by the FNV prime, one bit per cycle.
module mbf_mul
   import mbf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  unit_ctl_type ctl,
   input  logic [31:0]  a,
   output logic [31:0]  prod,
   output logic         done
);
   logic [31:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;

   // Shift-and-add over the 32 bits of the constant multiplier, modulo 2^32.
   always_comb begin
      acc_in = acc_ff; mcand_in = mcand_ff; cnt_in = cnt_ff; run_in = run_ff;
      done = 1'b0;
      if (ctl.start) begin
         acc_in = '0; mcand_in = a; cnt_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         if (FNV_MULT[cnt_ff]) acc_in = acc_ff + mcand_ff;
         mcand_in = {mcand_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in = 1'b0;
            done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) run_ff <= 1'b0;
      else run_ff <= run_in;
      acc_ff <= acc_in; mcand_ff <= mcand_in; cnt_ff <= cnt_in;
   end
   assign prod = acc_in;
endmodule

FILE: hdl/mbf_mod.sv
// Restoring remainder of a 32-bit hash by the filter size, one bit per cycle.
module mbf_mod
   import mbf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  unit_ctl_type      ctl,
   input  logic [31:0]       num,
   input  logic [SIZE_W-1:0] den,
   output logic [IDX_W-1:0]  rem,
   output logic              done
);
   logic [31:0]       num_ff, num_in;
   logic [SIZE_W:0]   r_ff, r_in, trial;
   logic [4:0]        cnt_ff, cnt_in;
   logic              run_ff, run_in;

   always_comb begin
      num_in = num_ff; r_in = r_ff; cnt_in = cnt_ff; run_in = run_ff;
      done = 1'b0;
      trial = {r_ff[SIZE_W-1:0], num_ff[31]};
      if (ctl.start) begin
         num_in = num; r_in = '0; cnt_in = '0; run_in = 1'b1;
      end else if (run_ff) begin
         r_in = (trial >= {1'b0, den}) ? trial - {1'b0, den} : trial;
         num_in = {num_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in = 1'b0;
            done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) run_ff <= 1'b0;
      else run_ff <= run_in;
      num_ff <= num_in; r_ff <= r_in; cnt_ff <= cnt_in;
   end
   assign rem = r_in[IDX_W-1:0];
endmodule

FILE: hdl/mac_bloom_filter_top.sv
// Top level of the MAC address Bloom filter.
//
//   channel   direction  ports
//   request   in         req_valid, req_ready, req_cmd, req_mac
//   response  out        rsp_valid, rsp_ready, rsp_hit
//   csr       in/out     csr_psel, csr_penable, csr_pwrite, csr_paddr, csr_pwdata, csr_prdata
//
// Each hash takes one setup step, six bit-serial multiplies and a bit-serial
// remainder, and a query adds its memory read. A request has up to 20 hashes;
// a query stops at its first clear bit. A clear request sweeps all 65536
// filter bits, one per cycle. After reset the same sweep runs before the first
// request is taken. Results sit in an output register, so a new request is
// taken while the last response waits; a stalled response holds the block in
// its final step.
module mac_bloom_filter_top
   import mbf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [MAC_W-1:0]  req_mac,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_hit,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   // Configuration registers, clamped on use to their legal ranges.
   logic [SIZE_W-1:0] size_ff;
   logic [NH_W-1:0]   nh_ff;
   logic              csr_wr;
   reg_type           csr_reg;

   assign csr_pready = 1'b1;
   assign csr_reg = reg_type'(csr_paddr[2]);
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[1:0] == 2'b00);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(MAX_BITS);
         nh_ff   <= NH_W'(7);
      end else if (csr_wr) begin
         case (csr_reg)
            REG_BIT_SIZE: size_ff <= csr_pwdata[SIZE_W-1:0];
            REG_NUM_HASH: nh_ff   <= csr_pwdata[NH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         case (csr_reg)
            REG_BIT_SIZE: csr_prdata = {{(32-SIZE_W){1'b0}}, size_ff};
            REG_NUM_HASH: csr_prdata = {{(32-NH_W){1'b0}}, nh_ff};
            default: csr_prdata = '0;
         endcase
      end
   end

   logic [SIZE_W-1:0] mod_eff;
   logic [NH_W-1:0]   cnt_eff;
   always_comb begin
      mod_eff = size_ff;
      if (size_ff == '0) mod_eff = SIZE_W'(1);
      else if (size_ff > SIZE_W'(MAX_BITS)) mod_eff = SIZE_W'(MAX_BITS);
      cnt_eff = nh_ff;
      if (nh_ff == '0) cnt_eff = NH_W'(1);
      else if (nh_ff > NH_W'(MAX_HASHES)) cnt_eff = NH_W'(MAX_HASHES);
   end

   // Sequencer state.
   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [MAC_W-1:0]  mac_ff, mac_in;
   logic [31:0]       h_ff, h_in;
   logic [2:0]        byte_ff, byte_in;
   logic [NH_W-1:0]   seed_ff, seed_in;
   logic [IDX_W:0]    wipe_ff, wipe_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              hit_ff, hit_in, rv_ff, rv_in;
   // Hit flag of the request being worked on, kept apart from the response.
   logic              hit_work_ff, hit_work_in;

   unit_ctl_type      mul_ctl, mod_ctl;
   logic [31:0]       prod;
   logic              mul_done, mod_done;
   logic [IDX_W-1:0]  rem;

   logic              ram_we, ram_wd, ram_rd;
   logic [IDX_W-1:0]  ram_addr;

   mbf_mul u_mul (.clock, .reset, .ctl(mul_ctl), .a(h_ff), .prod, .done(mul_done));
   mbf_mod u_mod (.clock, .reset, .ctl(mod_ctl), .num(h_ff), .den(mod_eff), .rem,
                  .done(mod_done));
   mbf_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_ram (.clock, .wr_en(ram_we), .addr(ram_addr),
                  .wdata(ram_wd), .rdata(ram_rd));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_hit = hit_ff;

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; mac_in = mac_ff; h_in = h_ff;
      byte_in = byte_ff; seed_in = seed_ff; wipe_in = wipe_ff; idx_in = idx_ff;
      hit_in = hit_ff; rv_in = rv_ff; hit_work_in = hit_work_ff;
      mul_ctl = '0; mod_ctl = '0;
      ram_we = 1'b0; ram_wd = 1'b0; ram_addr = idx_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         ST_WIPE: begin
            ram_we = 1'b1;
            ram_addr = wipe_ff[IDX_W-1:0];
            wipe_in = wipe_ff + 1'b1;
            if (wipe_ff[IDX_W-1:0] == '1) state_in = ST_DONE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in = cmd_type'(req_cmd);
               mac_in = req_mac;
               seed_in = '0;
               hit_work_in = 1'b0;
               case (cmd_type'(req_cmd))
                  CMD_ADD, CMD_QUERY: begin
                     hit_work_in = (cmd_type'(req_cmd) == CMD_QUERY);
                     state_in = ST_HASH;
                  end
                  CMD_CLEAR: begin
                     wipe_in = '0;
                     state_in = ST_WIPE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_HASH: begin
            // Fold in the first byte; its multiply starts in ST_MUL.
            h_in = FNV_START ^ {27'd0, seed_ff} ^ {24'd0, mac_ff[MAC_W-1 -: 8]};
            mac_in = {mac_ff[MAC_W-9:0], mac_ff[MAC_W-1 -: 8]};
            byte_in = 3'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mul_ctl.start = 1'b1;
            mul_ctl.busy = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            mul_ctl.busy = 1'b1;
            if (mul_done) begin
               if (byte_ff == 3'd5) begin
                  h_in = prod;
                  state_in = ST_MOD;
               end else begin
                  h_in = prod ^ {24'd0, mac_ff[MAC_W-1 -: 8]};
                  mac_in = {mac_ff[MAC_W-9:0], mac_ff[MAC_W-1 -: 8]};
                  byte_in = byte_ff + 3'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MOD: begin
            mod_ctl.start = 1'b1;
            mod_ctl.busy = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            mod_ctl.busy = 1'b1;
            if (mod_done) begin
               idx_in = rem;
               if (cmd_ff == CMD_ADD) begin
                  ram_we = 1'b1; ram_wd = 1'b1; ram_addr = rem;
                  seed_in = seed_ff + 1'b1;
                  state_in = (seed_ff + 1'b1 == cnt_eff) ? ST_DONE : ST_HASH;
               end else begin
                  ram_addr = rem;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            seed_in = seed_ff + 1'b1;
            if (!ram_rd) begin
               hit_work_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               state_in = (seed_ff + 1'b1 == cnt_eff) ? ST_DONE : ST_HASH;
            end
         end
         ST_DONE: begin
            // Reset sweep ends here with no response; the flag marks it.
            if (wipe_ff[IDX_W] && cmd_ff == CMD_NONE && !rv_ff && seed_ff == '1) begin
               state_in = ST_IDLE;
            end else if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               hit_in = hit_work_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The power-up sweep is tagged by an unused command and an all-ones seed.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
         rv_ff    <= 1'b0;
         wipe_ff  <= '0;
         cmd_ff   <= CMD_NONE;
         seed_ff  <= '1;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         wipe_ff  <= wipe_in;
         cmd_ff   <= cmd_in;
         seed_ff  <= seed_in;
      end
      mac_ff <= mac_in; h_ff <= h_in; byte_ff <= byte_in;
      idx_ff <= idx_in; hit_ff <= hit_in; hit_work_ff <= hit_work_in;
   end
endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the MAC address Bloom filter top level.
`timescale 1ns / 1ps

module tb_top
   import mbf_pkg::*;
;

   // The watchdog limit covers the sweep after reset or after a clear, the
   // slowest twenty-hash request and the long response hold-off.
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int LONG_HOLD      = 20000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_cmd;
   logic [MAC_W-1:0]  req_mac;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_hit;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   mac_bloom_filter_top i_dut (.*);

   // Shadow copy of the filter bits and of both registers.
   logic              filter_bits [MAX_BITS];
   logic [SIZE_W-1:0] shadow_size;
   logic [NH_W-1:0]   shadow_hashes;

   // Expected hit flags, oldest first.
   logic              hit_queue [$];
   logic [MAC_W-1:0]  added_macs [$];
   int                error_count;
   int                idle_cycles;
   bit                long_hold;

   typedef struct {
      cmd_type          cmd;
      logic [MAC_W-1:0] mac;
      int               hit;   // -1 means the hit comes from the predictor
   } vector_type;

   // Directed requests under the reset configuration.
   vector_type directed [] = '{
      '{CMD_QUERY, 48'h0,            0},   // empty filter after reset
      '{CMD_ADD,   48'h0,            0},
      '{CMD_QUERY, 48'h0,           -1},
      '{CMD_ADD,   48'hFFFF_FFFF_FFFF, 0},
      '{CMD_QUERY, 48'hFFFF_FFFF_FFFF, -1},
      '{CMD_QUERY, 48'h0123_4567_89AB, -1},
      '{CMD_NONE,  48'hFFFF_FFFF_FFFF, 0},  // unused code leaves the store alone
      '{CMD_QUERY, 48'hFFFF_FFFF_FFFF, -1},
      '{CMD_ADD,   48'h8000_0000_0001, 0},
      '{CMD_QUERY, 48'h8000_0000_0001, -1},
      '{CMD_QUERY, 48'h0000_0000_0001, -1},
      '{CMD_CLEAR, 48'h5A5A_5A5A_5A5A, 0},
      '{CMD_QUERY, 48'h0,            0},   // everything is gone after a clear
      '{CMD_QUERY, 48'hFFFF_FFFF_FFFF, 0},
      '{CMD_QUERY, 48'h8000_0000_0001, 0}
   };

   // Register settings of the random phases, with their request counts.
   // Out-of-range values check the saturation of both registers.
   int unsigned phase_size [] = '{65536, 1, 0, 131071, 65536, 64, 1000, 7, 4096};
   int unsigned phase_hash [] = '{7,     1, 0, 31,     20,    3,  2,    5, 1};
   int          phase_count[] = '{300,   150, 100, 25, 25,    400, 400,  200, 300};

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // Seeded FNV-1a over the six address bytes, first byte most significant.
   function automatic int unsigned filter_index(input logic [MAC_W-1:0] mac,
                                                input int unsigned seed,
                                                input int unsigned modulus);
      logic [31:0] h;
      h = FNV_START ^ seed;
      for (int b = 0; b < 6; b++) begin
         h = h ^ {24'd0, mac[47 - 8*b -: 8]};
         h = h * FNV_MULT;
      end
      return h % modulus;
   endfunction

   // Applies one request to the shadow filter and returns the expected hit.
   function automatic logic apply_request(input cmd_type cmd,
                                          input logic [MAC_W-1:0] mac);
      int unsigned modulus;
      int unsigned hashes;
      int unsigned idx;
      logic        hit;
      modulus = (shadow_size == 0) ? 1 : (shadow_size > MAX_BITS) ? MAX_BITS : shadow_size;
      hashes  = (shadow_hashes == 0) ? 1 :
                (shadow_hashes > MAX_HASHES) ? MAX_HASHES : shadow_hashes;
      hit = 1'b0;
      case (cmd)
         CMD_ADD: begin
            for (int i = 0; i < hashes; i++) begin
               idx = filter_index(mac, i, modulus);
               filter_bits[idx] = 1'b1;
            end
         end
         CMD_QUERY: begin
            hit = 1'b1;
            for (int i = 0; i < hashes; i++) begin
               idx = filter_index(mac, i, modulus);
               if (!filter_bits[idx]) hit = 1'b0;
            end
         end
         CMD_CLEAR: begin
            foreach (filter_bits[i]) filter_bits[i] = 1'b0;
         end
         default: ;
      endcase
      return hit;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(20, 4);
      return $urandom_range(300, 50);
   endfunction

   // Offers one request after a random gap and records its expected hit
   // at the edge where it is accepted.
   task automatic send_request(input cmd_type cmd, input logic [MAC_W-1:0] mac,
                               input int typed_hit);
      int   gap;
      logic predicted;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_mac   <= mac;
      do @(posedge clock); while (!req_ready);
      predicted = apply_request(cmd, mac);
      hit_queue.push_back(typed_hit < 0 ? predicted : typed_hit[0]);
   endtask

   task automatic csr_write(input reg_type which, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (which == REG_BIT_SIZE) shadow_size = value[SIZE_W-1:0];
      else shadow_hashes = value[NH_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Reads a register back and compares the bits that it holds.
   task automatic csr_check(input reg_type which);
      logic [31:0] value;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {which, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (which == REG_BIT_SIZE && value[SIZE_W-1:0] != shadow_size)
         report($sformatf("bit_size reads %0d, wrote %0d", value[SIZE_W-1:0], shadow_size));
      if (which == REG_NUM_HASH && value[NH_W-1:0] != shadow_hashes)
         report($sformatf("num_hash reads %0d, wrote %0d", value[NH_W-1:0], shadow_hashes));
   endtask

   // Waits until every expected response has come back and the block is
   // quiet again, so that a register can be written safely.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Random traffic: mostly adds followed by queries of the same addresses,
   // with fresh queries, the unused code and a rare clear mixed in.
   task automatic random_phase(input int count);
      int               roll;
      cmd_type          cmd;
      logic [MAC_W-1:0] mac;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(999);
         mac  = MAC_W'({$urandom, $urandom});
         if ($urandom_range(49) == 0) mac = $urandom_range(1) ? '1 : '0;
         if (roll < 2) begin
            cmd = CMD_CLEAR;
            added_macs.delete();
         end else if (roll < 40) begin
            cmd = CMD_NONE;
         end else if (roll < 450) begin
            cmd = CMD_ADD;
            added_macs.push_back(mac);
            if (added_macs.size() > 64) void'(added_macs.pop_front());
         end else begin
            cmd = CMD_QUERY;
            if (roll < 800 && added_macs.size() != 0)
               mac = added_macs[$urandom_range(added_macs.size() - 1)];
         end
         send_request(cmd, mac, -1);
      end
   endtask

   // Response side: random ready pattern, plus one long hold-off on request
   // so that the block backs up and stops taking requests.
   initial begin : response_ready
      int low_len;
      int high_len;
      rsp_ready = 1'b0;
      forever begin
         if (long_hold) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold = 1'b0;
         end
         low_len  = pick_gap();
         high_len = $urandom_range(3) == 0 ? $urandom_range(400, 50) : $urandom_range(8, 1);
         if (low_len > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (low_len - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         repeat (high_len - 1) @(negedge clock);
      end
   end

   // Response checker: every accepted response is matched against the
   // oldest expected hit.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (hit_queue.size() == 0) begin
            report($sformatf("response hit=%0b with nothing expected", rsp_hit));
         end else begin
            if (rsp_hit !== hit_queue[0])
               report($sformatf("hit is %b, expected %b", rsp_hit, hit_queue[0]));
            void'(hit_queue.pop_front());
         end
      end
   end

   // Watchdog: any handshake on any port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : main_sequence
      error_count   = 0;
      idle_cycles   = 0;
      long_hold     = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cmd       = CMD_ADD;
      req_mac       = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      shadow_size   = SIZE_W'(MAX_BITS);
      shadow_hashes = NH_W'(7);
      foreach (filter_bits[i]) filter_bits[i] = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The reset values must read back before anything is written.
      csr_check(REG_BIT_SIZE);
      csr_check(REG_NUM_HASH);

      // Directed requests, checked against typed-in hits where they are
      // obvious and against the shadow filter otherwise.
      foreach (directed[i]) send_request(directed[i].cmd, directed[i].mac, directed[i].hit);

      for (int p = 0; p < phase_count.size(); p++) begin
         drain();
         csr_write(REG_BIT_SIZE, phase_size[p]);
         csr_write(REG_NUM_HASH, phase_hash[p]);
         csr_check(REG_BIT_SIZE);
         csr_check(REG_NUM_HASH);
         // In the phase with a 64-bit filter the response side stalls for a long
         // stretch while requests keep coming.
         if (p == 5) long_hold = 1'b1;
         random_phase(phase_count[p]);
      end

      drain();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
